// ===== sv/rv32i_instruction_decoder_unit_macros.svh =====
// ---------------------------------------------------------------------------
// RV32I decoder assertion macros
// Concurrent check helpers shared by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RVID_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RVID_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rvid_pkg.sv =====
// ---------------------------------------------------------------------------
// RV32I decoder package
// Opcodes, class and operation codes, result type and immediate helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package rvid_pkg;

   localparam int unsigned InstrWidth = 32;

   // major opcodes
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // instruction classes
   localparam logic [3:0] CLASS_LUI     = 4'd0;
   localparam logic [3:0] CLASS_JAL     = 4'd1;
   localparam logic [3:0] CLASS_JALR    = 4'd2;
   localparam logic [3:0] CLASS_AUIPC   = 4'd3;
   localparam logic [3:0] CLASS_INT_IMM = 4'd4;
   localparam logic [3:0] CLASS_INT_REG = 4'd5;
   localparam logic [3:0] CLASS_BRANCH  = 4'd6;
   localparam logic [3:0] CLASS_STORE   = 4'd7;
   localparam logic [3:0] CLASS_LOAD    = 4'd8;
   localparam logic [3:0] CLASS_FENCE   = 4'd9;

   // operations
   localparam logic [4:0] OP_UNKNOWN = 5'd0;
   localparam logic [4:0] OP_ADD     = 5'd1;
   localparam logic [4:0] OP_SUB     = 5'd2;
   localparam logic [4:0] OP_SLL     = 5'd3;
   localparam logic [4:0] OP_SLT     = 5'd4;
   localparam logic [4:0] OP_SLTU    = 5'd5;
   localparam logic [4:0] OP_XOR     = 5'd6;
   localparam logic [4:0] OP_SRL     = 5'd7;
   localparam logic [4:0] OP_SRA     = 5'd8;
   localparam logic [4:0] OP_OR      = 5'd9;
   localparam logic [4:0] OP_AND     = 5'd10;
   localparam logic [4:0] OP_MEM_B   = 5'd11;
   localparam logic [4:0] OP_MEM_H   = 5'd12;
   localparam logic [4:0] OP_MEM_W   = 5'd13;
   localparam logic [4:0] OP_MEM_BU  = 5'd14;
   localparam logic [4:0] OP_MEM_HU  = 5'd15;
   localparam logic [4:0] OP_BR_EQ   = 5'd16;
   localparam logic [4:0] OP_BR_NE   = 5'd17;
   localparam logic [4:0] OP_BR_LT   = 5'd18;
   localparam logic [4:0] OP_BR_GE   = 5'd19;
   localparam logic [4:0] OP_BR_LTU  = 5'd20;
   localparam logic [4:0] OP_BR_GEU  = 5'd21;

   // funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_MEM_B  = 3'd0;
   localparam logic [2:0] F3_MEM_H  = 3'd1;
   localparam logic [2:0] F3_MEM_W  = 3'd2;
   localparam logic [2:0] F3_MEM_BU = 3'd4;
   localparam logic [2:0] F3_MEM_HU = 3'd5;
   localparam logic [2:0] F3_BR_EQ  = 3'd0;
   localparam logic [2:0] F3_BR_NE  = 3'd1;
   localparam logic [2:0] F3_BR_LT  = 3'd4;
   localparam logic [2:0] F3_BR_GE  = 3'd5;
   localparam logic [2:0] F3_BR_LTU = 3'd6;
   localparam logic [2:0] F3_BR_GEU = 3'd7;

   typedef struct packed {
      logic [3:0]         inst_class;
      logic [4:0]         operation;
      logic signed [31:0] immediate;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic [2:0]         minor_op;
      logic [6:0]         major_op;
      logic               decode_error;
   } decode_result_type;

   function automatic logic [4:0] alu_op(input logic [2:0] f3);
      logic [4:0] op;
      case (f3)
         F3_ADD:  op = OP_ADD;
         F3_SLL:  op = OP_SLL;
         F3_SLT:  op = OP_SLT;
         F3_SLTU: op = OP_SLTU;
         F3_XOR:  op = OP_XOR;
         F3_SR:   op = OP_SRL;
         F3_OR:   op = OP_OR;
         default: op = OP_AND;
      endcase
      return op;
   endfunction

   function automatic logic [31:0] imm_i(input logic [31:0] w);
      return {{20{w[31]}}, w[31:20]};
   endfunction

   function automatic logic [31:0] imm_s(input logic [31:0] w);
      return {{20{w[31]}}, w[31:25], w[11:7]};
   endfunction

   function automatic logic [31:0] imm_b(input logic [31:0] w);
      return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   endfunction

   function automatic logic [31:0] imm_u(input logic [31:0] w);
      return {w[31:12], 12'b0};
   endfunction

   function automatic logic [31:0] imm_j(input logic [31:0] w);
      return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   endfunction

endpackage

`default_nettype wire

// ===== sv/rvid_req_if.sv =====
// ---------------------------------------------------------------------------
// RV32I decoder request channel
// Valid/ready channel carrying one raw instruction word per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rvid_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

`default_nettype wire

// ===== sv/rvid_rsp_if.sv =====
// ---------------------------------------------------------------------------
// RV32I decoder response channel
// Valid/ready channel carrying one decoded instruction per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rvid_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         inst_class;
   logic [4:0]         operation;
   logic signed [31:0] immediate;
   logic [4:0]         dest_reg;
   logic [4:0]         src1_reg;
   logic [4:0]         src2_reg;
   logic [2:0]         minor_op;
   logic [6:0]         major_op;
   logic               decode_error;

   modport source (output valid, output inst_class, output operation, output immediate,
                   output dest_reg, output src1_reg, output src2_reg, output minor_op,
                   output major_op, output decode_error, input ready);
   modport sink   (input valid, input inst_class, input operation, input immediate,
                   input dest_reg, input src1_reg, input src2_reg, input minor_op,
                   input major_op, input decode_error, output ready);
endinterface

`default_nettype wire

// ===== sv/rvid_decode.sv =====
// ---------------------------------------------------------------------------
// RV32I decoder core
// Combinational decode of one instruction word into its fields.
// ---------------------------------------------------------------------------
`default_nettype none

module rvid_decode
   import rvid_pkg::*;
(
   input  wire logic [31:0]       instr_word,
   output decode_result_type      result
);

   logic [6:0] opcode;
   logic [4:0] rd;
   logic [4:0] rs1;
   logic [4:0] rs2;
   logic [2:0] f3;
   logic [6:0] f7;

   assign opcode = instr_word[6:0];
   assign rd     = instr_word[11:7];
   assign rs1    = instr_word[19:15];
   assign rs2    = instr_word[24:20];
   assign f3     = instr_word[14:12];
   assign f7     = instr_word[31:25];

   always_comb begin
      result = '0;
      case (opcode)
         OPC_LUI, OPC_AUIPC: begin
            result.inst_class = (opcode == OPC_LUI) ? CLASS_LUI : CLASS_AUIPC;
            result.immediate  = $signed(imm_u(instr_word));
            result.dest_reg   = rd;
            result.operation  = OP_ADD;
         end
         OPC_JAL: begin
            result.inst_class = CLASS_JAL;
            result.immediate  = $signed(imm_j(instr_word));
            result.dest_reg   = rd;
            result.operation  = OP_ADD;
         end
         OPC_JALR: begin
            result.inst_class = CLASS_JALR;
            result.immediate  = $signed(imm_i(instr_word));
            result.dest_reg   = rd;
            result.src1_reg   = rs1;
            result.minor_op   = f3;
         end
         OPC_OP_IMM: begin
            result.inst_class = CLASS_INT_IMM;
            result.immediate  = $signed(imm_i(instr_word));
            result.dest_reg   = rd;
            result.src1_reg   = rs1;
            result.minor_op   = f3;
            if (f3 inside {F3_SLL, F3_SR}) begin
               // shifts: upper immediate bits act as funct7
               if (f7 == F7_BASE) begin
                  result.operation = (f3 == F3_SLL) ? OP_SLL : OP_SRL;
                  result.immediate = $signed({27'b0, rs2});
               end else if (f7 == F7_ALT && f3 == F3_SR) begin
                  result.operation = OP_SRA;
                  result.immediate = $signed({27'b0, rs2});
               end else begin
                  result.decode_error = 1'b1;
               end
            end else begin
               result.operation = alu_op(f3);
            end
         end
         OPC_OP: begin
            result.inst_class = CLASS_INT_REG;
            result.dest_reg   = rd;
            result.src1_reg   = rs1;
            result.src2_reg   = rs2;
            result.minor_op   = f3;
            result.major_op   = f7;
            if (f7 == F7_BASE) begin
               result.operation = alu_op(f3);
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               result.operation = OP_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               result.operation = OP_SRA;
            end else begin
               result.decode_error = 1'b1;
            end
         end
         OPC_BRANCH: begin
            result.inst_class = CLASS_BRANCH;
            result.immediate  = $signed(imm_b(instr_word));
            result.src1_reg   = rs1;
            result.src2_reg   = rs2;
            result.minor_op   = f3;
            case (f3)
               F3_BR_EQ:  result.operation = OP_BR_EQ;
               F3_BR_NE:  result.operation = OP_BR_NE;
               F3_BR_LT:  result.operation = OP_BR_LT;
               F3_BR_GE:  result.operation = OP_BR_GE;
               F3_BR_LTU: result.operation = OP_BR_LTU;
               F3_BR_GEU: result.operation = OP_BR_GEU;
               default:   result.decode_error = 1'b1;
            endcase
         end
         OPC_STORE: begin
            result.inst_class = CLASS_STORE;
            result.immediate  = $signed(imm_s(instr_word));
            result.src1_reg   = rs1;
            result.src2_reg   = rs2;
            result.minor_op   = f3;
            case (f3)
               F3_MEM_B: result.operation = OP_MEM_B;
               F3_MEM_H: result.operation = OP_MEM_H;
               F3_MEM_W: result.operation = OP_MEM_W;
               default:  result.decode_error = 1'b1;
            endcase
         end
         OPC_LOAD: begin
            result.inst_class = CLASS_LOAD;
            result.immediate  = $signed(imm_i(instr_word));
            result.dest_reg   = rd;
            result.src1_reg   = rs1;
            result.minor_op   = f3;
            case (f3)
               F3_MEM_B:  result.operation = OP_MEM_B;
               F3_MEM_H:  result.operation = OP_MEM_H;
               F3_MEM_W:  result.operation = OP_MEM_W;
               F3_MEM_BU: result.operation = OP_MEM_BU;
               F3_MEM_HU: result.operation = OP_MEM_HU;
               default:   result.decode_error = 1'b1;
            endcase
         end
         OPC_FENCE: begin
            result.inst_class = CLASS_FENCE;
         end
         default: begin
            result.decode_error = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/rv32i_instruction_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// RV32I instruction decoder unit
// Registered decode stage: input register, decode logic, result register.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one 32-bit instruction word per transfer (valid/ready).
//   rsp carries the decoded instruction: class, operation, immediate,
//   register numbers, funct3/funct7 and an error flag for words that are
//   not valid RV32I.
//   A word accepted on req enters the input register, is decoded there
//   combinationally and is captured in the result register, from which it
//   is offered on rsp.
//   Throughput: one word per cycle, sustained, as long as rsp is taken.
//   req.ready stays high while the input register is empty or can move
//   into the result register this cycle.
//   When rsp stalls, the result register holds its item and the input
//   register can still take one more word; then req.ready drops until
//   the result is taken.
//   Reset (synchronous, active high) empties both registers; no item is
//   lost or repeated across a stall.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rv32i_instruction_decoder_unit_macros.svh"

module rv32i_instruction_decoder_unit
   import rvid_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   rvid_req_if.sink    req,
   rvid_rsp_if.source  rsp
);

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [31:0]       s1_word_ff;
   logic [31:0]       s1_word_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   decode_result_type rsp_ff;
   decode_result_type rsp_in;
   decode_result_type dec_result;
   logic              out_free;
   logic              s1_free;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req.ready = s1_free;

   rvid_decode u_decode (
      .instr_word (s1_word_ff),
      .result     (dec_result)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_word_in   = s1_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_free) begin
         s1_valid_in = req.valid;
         s1_word_in  = req.instr_word;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in       = dec_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_word_ff <= s1_word_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.inst_class   = rsp_ff.inst_class;
   assign rsp.operation    = rsp_ff.operation;
   assign rsp.immediate    = rsp_ff.immediate;
   assign rsp.dest_reg     = rsp_ff.dest_reg;
   assign rsp.src1_reg     = rsp_ff.src1_reg;
   assign rsp.src2_reg     = rsp_ff.src2_reg;
   assign rsp.minor_op     = rsp_ff.minor_op;
   assign rsp.major_op     = rsp_ff.major_op;
   assign rsp.decode_error = rsp_ff.decode_error;

   // a decoded word moving out of the input register must show up on rsp
   `RVID_ASSERT_NXT(a_s1_moves_out, clock, reset,
      s1_valid_ff && out_free, rsp_valid_ff, "input register item lost")
   // every rejected word carries no operation
   `RVID_ASSERT_IMP(a_err_no_op, clock, reset,
      rsp_valid_ff && rsp_ff.decode_error, rsp_ff.operation == OP_UNKNOWN,
      "error with operation set")
   // fence never flags an error
   `RVID_ASSERT_IMP(a_fence_ok, clock, reset,
      rsp_valid_ff && rsp_ff.inst_class == CLASS_FENCE,
      !rsp_ff.decode_error && rsp_ff.operation == OP_UNKNOWN, "bad fence decode")
   // valid immediate shifts carry only a 5-bit shift amount
   `RVID_ASSERT_IMP(a_shamt_narrow, clock, reset,
      rsp_valid_ff && rsp_ff.inst_class == CLASS_INT_IMM &&
      (rsp_ff.operation == OP_SLL || rsp_ff.operation == OP_SRL ||
       rsp_ff.operation == OP_SRA),
      rsp_ff.immediate[31:5] == 27'd0, "shift amount too wide")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// RV32I instruction decoder testbench
// Drives raw instruction words through the decode stage and compares every
// decoded result against an in-bench decode predictor, field by field.
// Directed corner words come first, then random words biased toward legal
// opcodes, under four handshake phases with no gaps, sender gaps, receiver
// stalls, and both together.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rvid_pkg::*;

   localparam int unsigned CLK_HALF       = 6;
   localparam int unsigned RESET_CYCLES   = 11;
   localparam int unsigned WORDS_PER_PHASE = 500;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = 8;

   logic clock = 1'b0;
   logic reset;

   rvid_req_if req_ch ();
   rvid_rsp_if rsp_ch ();

   rv32i_instruction_decoder_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #(CLK_HALF) clock = ~clock;

   // decode table for base ALU funct3 values
   function automatic logic [4:0] alu_from_funct3(input logic [2:0] f3);
      case (f3)
         F3_ADD:  return OP_ADD;
         F3_SLL:  return OP_SLL;
         F3_SLT:  return OP_SLT;
         F3_SLTU: return OP_SLTU;
         F3_XOR:  return OP_XOR;
         F3_SR:   return OP_SRL;
         F3_OR:   return OP_OR;
         default: return OP_AND;
      endcase
   endfunction

   function automatic decode_result_type decode_word(input logic [31:0] w);
      decode_result_type r;
      logic [31:0]       i_form;
      logic [2:0]        f3;
      logic [6:0]        f7;
      logic              err;
      r      = '0;
      err    = 1'b0;
      f3     = w[14:12];
      f7     = w[31:25];
      i_form = {{20{w[31]}}, w[31:20]};
      case (w[6:0])
         OPC_LUI, OPC_AUIPC: begin
            r.inst_class = (w[6:0] == OPC_LUI) ? CLASS_LUI : CLASS_AUIPC;
            r.immediate  = {w[31:12], 12'h000};
            r.dest_reg   = w[11:7];
            r.operation  = OP_ADD;
         end
         OPC_JAL: begin
            r.inst_class = CLASS_JAL;
            r.immediate  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            r.dest_reg   = w[11:7];
            r.operation  = OP_ADD;
         end
         OPC_JALR: begin
            // funct3 is passed through but not checked
            r.inst_class = CLASS_JALR;
            r.immediate  = i_form;
            r.dest_reg   = w[11:7];
            r.src1_reg   = w[19:15];
            r.minor_op   = f3;
            r.operation  = OP_UNKNOWN;
         end
         OPC_OP_IMM: begin
            r.inst_class = CLASS_INT_IMM;
            r.immediate  = i_form;
            r.dest_reg   = w[11:7];
            r.src1_reg   = w[19:15];
            r.minor_op   = f3;
            if (f3 == F3_SLL || f3 == F3_SR) begin
               // imm[11:5] is the funct7 position
               if (f7 == F7_BASE) r.operation = (f3 == F3_SLL) ? OP_SLL : OP_SRL;
               else if (f7 == F7_ALT && f3 == F3_SR) r.operation = OP_SRA;
               else err = 1'b1;
               // bad shift keeps the full immediate
               if (!err) r.immediate = {27'd0, w[24:20]};
            end else begin
               r.operation = alu_from_funct3(f3);
            end
         end
         OPC_OP: begin
            r.inst_class = CLASS_INT_REG;
            r.dest_reg   = w[11:7];
            r.src1_reg   = w[19:15];
            r.src2_reg   = w[24:20];
            r.minor_op   = f3;
            r.major_op   = f7;
            if (f7 == F7_BASE) r.operation = alu_from_funct3(f3);
            else if (f7 == F7_ALT && f3 == F3_ADD) r.operation = OP_SUB;
            else if (f7 == F7_ALT && f3 == F3_SR) r.operation = OP_SRA;
            else err = 1'b1;
         end
         OPC_BRANCH: begin
            r.inst_class = CLASS_BRANCH;
            r.immediate  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            r.src1_reg   = w[19:15];
            r.src2_reg   = w[24:20];
            r.minor_op   = f3;
            case (f3)
               F3_BR_EQ:  r.operation = OP_BR_EQ;
               F3_BR_NE:  r.operation = OP_BR_NE;
               F3_BR_LT:  r.operation = OP_BR_LT;
               F3_BR_GE:  r.operation = OP_BR_GE;
               F3_BR_LTU: r.operation = OP_BR_LTU;
               F3_BR_GEU: r.operation = OP_BR_GEU;
               default:   err = 1'b1;
            endcase
         end
         OPC_STORE: begin
            r.inst_class = CLASS_STORE;
            r.immediate  = {{20{w[31]}}, w[31:25], w[11:7]};
            r.src1_reg   = w[19:15];
            r.src2_reg   = w[24:20];
            r.minor_op   = f3;
            case (f3)
               F3_MEM_B: r.operation = OP_MEM_B;
               F3_MEM_H: r.operation = OP_MEM_H;
               F3_MEM_W: r.operation = OP_MEM_W;
               default:  err = 1'b1;
            endcase
         end
         OPC_LOAD: begin
            r.inst_class = CLASS_LOAD;
            r.immediate  = i_form;
            r.dest_reg   = w[11:7];
            r.src1_reg   = w[19:15];
            r.minor_op   = f3;
            case (f3)
               F3_MEM_B:  r.operation = OP_MEM_B;
               F3_MEM_H:  r.operation = OP_MEM_H;
               F3_MEM_W:  r.operation = OP_MEM_W;
               F3_MEM_BU: r.operation = OP_MEM_BU;
               F3_MEM_HU: r.operation = OP_MEM_HU;
               default:   err = 1'b1;
            endcase
         end
         OPC_FENCE: r.inst_class = CLASS_FENCE;
         default:   err = 1'b1;
      endcase
      r.decode_error = err;
      return r;
   endfunction

   class decode_scoreboard;
      decode_result_type expected_q[$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       flagged;

      function new();
         mismatches = 0;
         checked    = 0;
         flagged    = 0;
      endfunction

      function void note_word(input logic [31:0] w);
         expected_q.push_back(decode_word(w));
      endfunction

      function int unsigned pending_count();
         return expected_q.size();
      endfunction

      task report(input string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(input decode_result_type got);
         decode_result_type exp;
         if (expected_q.size() == 0) begin
            report("decoded result with no instruction outstanding");
         end else begin
            exp = expected_q.pop_front();
            checked++;
            if (exp.decode_error) flagged++;
            if (got.inst_class !== exp.inst_class)
               report($sformatf("inst_class got %0d exp %0d", got.inst_class, exp.inst_class));
            if (got.operation !== exp.operation)
               report($sformatf("operation got %0d exp %0d", got.operation, exp.operation));
            if (got.immediate !== exp.immediate)
               report($sformatf("immediate got %h exp %h", got.immediate, exp.immediate));
            if (got.dest_reg !== exp.dest_reg)
               report($sformatf("dest_reg got %0d exp %0d", got.dest_reg, exp.dest_reg));
            if (got.src1_reg !== exp.src1_reg)
               report($sformatf("src1_reg got %0d exp %0d", got.src1_reg, exp.src1_reg));
            if (got.src2_reg !== exp.src2_reg)
               report($sformatf("src2_reg got %0d exp %0d", got.src2_reg, exp.src2_reg));
            if (got.minor_op !== exp.minor_op)
               report($sformatf("minor_op got %0d exp %0d", got.minor_op, exp.minor_op));
            if (got.major_op !== exp.major_op)
               report($sformatf("major_op got %0d exp %0d", got.major_op, exp.major_op));
            if (got.decode_error !== exp.decode_error)
               report($sformatf("decode_error got %b exp %b",
                                got.decode_error, exp.decode_error));
         end
      endtask
   endclass

   decode_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned words_sent    = 0;

   logic [6:0]  opcode_tab [0:9];
   logic [31:0] directed_words [0:24];

   // transfer monitor: samples pre-edge values at each rising edge
   always @(posedge clock) begin
      decode_result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_word(req_ch.instr_word);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.inst_class   = rsp_ch.inst_class;
            got.operation    = rsp_ch.operation;
            got.immediate    = rsp_ch.immediate;
            got.dest_reg     = rsp_ch.dest_reg;
            got.src1_reg     = rsp_ch.src1_reg;
            got.src2_reg     = rsp_ch.src2_reg;
            got.minor_op     = rsp_ch.minor_op;
            got.major_op     = rsp_ch.major_op;
            got.decode_error = rsp_ch.decode_error;
            sb.check_result(got);
         end
      end
   end

   // result-side back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, sb.pending_count());
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // holds valid until the word transfers; gaps are inserted before valid rises
   task automatic send_word(input logic [31:0] w);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.instr_word <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // mostly legal opcodes with random fields, funct7 leaning to the legal codes
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int unsigned pick;
      w = $urandom();
      if ($urandom_range(0, 99) < 85) begin
         w[6:0] = opcode_tab[$urandom_range(0, 9)];
         if (w[6:0] == OPC_OP || w[6:0] == OPC_OP_IMM) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) w[31:25] = F7_BASE;
            else if (pick < 8) w[31:25] = F7_ALT;
         end
      end
      return w;
   endfunction

   initial begin
      int unsigned send_tab [0:3];
      int unsigned stall_tab [0:3];
      send_tab  = '{0, 68, 0, 30};
      stall_tab = '{0, 0, 68, 30};
      opcode_tab = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_OP_IMM,
                     OPC_OP, OPC_BRANCH, OPC_STORE, OPC_LOAD, OPC_FENCE};
      directed_words = '{
         32'h0000_0000,
         32'hFFFF_FFFF,
         {20'hFFFFF, 5'd31, OPC_LUI},
         {20'h80000, 5'd1, OPC_AUIPC},
         {1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL},
         {12'h7FF, 5'd31, 3'd7, 5'd15, OPC_JALR},
         {12'h800, 5'd0, F3_ADD, 5'd31, OPC_OP_IMM},
         {F7_BASE, 5'd31, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM},
         {F7_ALT, 5'd31, 5'd3, F3_SR, 5'd4, OPC_OP_IMM},
         {F7_ALT, 5'd7, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM},
         {7'h01, 5'd7, 5'd3, F3_SR, 5'd4, OPC_OP_IMM},
         {F7_BASE, 5'd0, 5'd1, F3_SLTU, 5'd2, OPC_OP_IMM},
         {F7_ALT, 5'd31, 5'd30, F3_ADD, 5'd29, OPC_OP},
         {F7_ALT, 5'd1, 5'd2, F3_SR, 5'd3, OPC_OP},
         {F7_BASE, 5'd31, 5'd31, F3_AND, 5'd31, OPC_OP},
         {7'h01, 5'd5, 5'd6, F3_XOR, 5'd7, OPC_OP},
         {F7_ALT, 5'd5, 5'd6, F3_AND, 5'd7, OPC_OP},
         {7'h7F, 5'd31, 5'd31, F3_BR_GEU, 5'h1F, OPC_BRANCH},
         {7'h00, 5'd1, 5'd2, 3'd2, 5'd0, OPC_BRANCH},
         {7'h40, 5'd9, 5'd8, F3_MEM_W, 5'd0, OPC_STORE},
         {7'h3F, 5'd9, 5'd8, 3'd3, 5'h1F, OPC_STORE},
         {12'hFFF, 5'd2, F3_MEM_HU, 5'd3, OPC_LOAD},
         {12'h001, 5'd2, 3'd3, 5'd3, OPC_LOAD},
         {4'hF, 4'hF, 4'hF, 5'd31, 3'd7, 5'd31, OPC_FENCE},
         {25'h1ABCDEF, 7'h7B}
      };

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.instr_word = '0;
      rsp_ch.ready      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) send_word(directed_words[i]);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_tab[phase];
         rsp_stall_pct = stall_tab[phase];
         repeat (WORDS_PER_PHASE) send_word(random_word());
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Decoded %0d instruction words, %0d of them flagged as invalid RV32I,",
               sb.checked, sb.flagged);
      $display("over directed corners and four sender/receiver throttling phases.");
      if (sb.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d field mismatches", sb.mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
